FILE: sv/tcpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tcpq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [7:0] THRESHOLD_RESET = 8'd60;

   localparam logic [1:0] MODE_INSERT   = 2'd0;
   localparam logic [1:0] MODE_SERVE    = 2'd1;
   localparam logic [1:0] MODE_WITHDRAW = 2'd2;
   localparam logic [1:0] MODE_QUERY    = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] entry_id;
      logic [7:0]  entry_age;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [15:0] served_id;
      logic [7:0]  found_age;
      logic [4:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [7:0]  age;
   } slot_type;

endpackage
`default_nettype wire

FILE: sv/tcpq_store.sv
`timescale 1ns / 1ps
`default_nettype none
module tcpq_store (
   input  wire                              clock,
   input  wire                              wr_en,
   input  wire  [tcpq_pkg::IDX_W-1:0]       wr_addr,
   input  wire  tcpq_pkg::slot_type         wr_data,
   input  wire                              rd_en,
   input  wire  [tcpq_pkg::IDX_W-1:0]       rd_addr,
   output tcpq_pkg::slot_type               rd_data
);
   import tcpq_pkg::*;

   slot_type mem [CAPACITY];
   slot_type rd_data_ff;

   // slots in queue order, head at address zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/two_class_priority_queue_with_cancel.sv
`timescale 1ns / 1ps
`default_nettype none
// a request's time grows with the slots read by the id search and the slots shifted;
// requests are taken one at a time, and the single read port of the slot memory
// reads one slot per read state, each followed by a compare or write state
// a result is held in an output register and the next request is taken while it waits
// reset (synchronous, active high) empties the queue and sets the threshold to 60;
// the slot memory is not cleared, only occupied slots are ever read
module two_class_priority_queue_with_cancel (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  tcpq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output tcpq_pkg::rsp_type     rsp_data,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [7:0]            csr_wdata
);
   import tcpq_pkg::*;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0; // waiting for a request
   localparam logic [2:0] S_RD   = 3'd1; // issue search read
   localparam logic [2:0] S_CMP  = 3'd2; // compare read slot
   localparam logic [2:0] S_MRD  = 3'd3; // close gap: read next slot
   localparam logic [2:0] S_MWR  = 3'd4; // close gap: write it one lower
   localparam logic [2:0] S_IRD  = 3'd5; // open gap: read slot below
   localparam logic [2:0] S_IWR  = 3'd6; // open gap: write it one higher
   localparam logic [2:0] S_FIN  = 3'd7; // hand result to output register

   logic [2:0]       state_ff, state_in;
   req_type          op_ff, op_in;
   logic             pref_ins_ff, pref_ins_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] pref_ff, pref_in;
   logic [7:0]       thr_ff;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   slot_type         wr_data, rd_data;
   logic             req_xfer, load_rsp;
   logic [CNT_W-1:0] idx_up;

   tcpq_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign load_rsp  = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign idx_up    = idx_ff + 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      pref_ins_in = pref_ins_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      total_in    = total_ff;
      pref_in     = pref_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = rd_data;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               op_in  = req_data;
               idx_in = '0;
               res_in = '0;
               if (req_data.mode == MODE_INSERT &&
                   total_ff == CNT_W'(CAPACITY)) begin
                  state_in = S_FIN; // full: refused
               end else if (req_data.mode == MODE_SERVE && total_ff == '0) begin
                  state_in = S_FIN; // empty
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff == total_ff) begin
               // search ran off the end: id absent
               if (op_ff.mode == MODE_INSERT) begin
                  pref_ins_in = (op_ff.entry_age >= thr_ff);
                  pos_in      = (op_ff.entry_age >= thr_ff) ? pref_ff : total_ff;
                  state_in    = S_IRD;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               rd_en    = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (op_ff.mode == MODE_SERVE || rd_data.id == op_ff.entry_id) begin
               case (op_ff.mode)
                  MODE_INSERT: begin
                     state_in = S_FIN; // duplicate id: refused
                  end
                  MODE_QUERY: begin
                     res_in.ok        = 1'b1;
                     res_in.found_age = rd_data.age;
                     state_in         = S_FIN;
                  end
                  default: begin
                     res_in.ok = 1'b1;
                     if (op_ff.mode == MODE_SERVE) begin
                        res_in.served_id = rd_data.id;
                     end
                     pos_in   = idx_ff;
                     state_in = S_MRD;
                  end
               endcase
            end else begin
               idx_in   = idx_up;
               state_in = S_RD;
            end
         end
         S_MRD: begin
            if (idx_up < total_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_up[IDX_W-1:0];
               state_in = S_MWR;
            end else begin
               total_in = total_ff - 1'b1;
               if (pos_ff < pref_ff) begin
                  pref_in = pref_ff - 1'b1;
               end
               state_in = S_FIN;
            end
         end
         S_MWR: begin
            wr_en    = 1'b1;
            idx_in   = idx_up;
            state_in = S_MRD;
         end
         S_IRD: begin
            if (idx_ff > pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = IDX_W'(idx_ff - 1'b1);
               state_in = S_IWR;
            end else begin
               // gap is open at pos: place the new entry
               wr_en        = 1'b1;
               wr_addr      = pos_ff[IDX_W-1:0];
               wr_data.id   = op_ff.entry_id;
               wr_data.age  = op_ff.entry_age;
               total_in     = total_ff + 1'b1;
               if (pref_ins_ff) begin
                  pref_in = pref_ff + 1'b1;
               end
               res_in.ok = 1'b1;
               state_in  = S_FIN;
            end
         end
         S_IWR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - 1'b1;
            state_in = S_IRD;
         end
         S_FIN: begin
            res_in.entry_count = 5'(total_ff);
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         pref_ff      <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         pref_ff  <= pref_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_wdata;
         end
         // output register: loaded from the finished result, freed by a transfer
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pref_ins_ff <= pref_ins_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      res_ff      <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_in;
      end
   end

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_pref_bound: assert property (@(posedge clock) disable iff (reset)
      pref_ff <= total_ff)
      else $error("preferred count exceeds entry count");

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("request transfer did not start a sequence");

   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

FILE: sim/two_class_priority_queue_with_cancel_tb.sv
`timescale 1ns / 1ps
module two_class_priority_queue_with_cancel_tb;
   import tcpq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_wdata = '0;

   always #2 clock = ~clock;

   two_class_priority_queue_with_cancel u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // shadow copy of the queue, head at index 0, preferred entries first
   logic [15:0] q_ids  [CAPACITY];
   logic [7:0]  q_ages [CAPACITY];
   int          n_pref;
   int          n_held;
   logic [7:0]  age_threshold;

   rsp_type expected_rsps[$];
   int      error_count = 0;
   bit      send_gaps = 1'b1;
   bit      drain_gaps = 1'b1;

   function automatic int locate_id(logic [15:0] id);
      for (int i = 0; i < n_held; i++)
         if (q_ids[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < n_held; i++) begin
         q_ids[i]  = q_ids[i + 1];
         q_ages[i] = q_ages[i + 1];
      end
      if (pos < n_pref) n_pref--;
      n_held--;
   endfunction

   // work out the result of one request and update the shadow queue
   function automatic rsp_type apply_request(req_type rq);
      rsp_type r;
      int pos;
      r = '0;
      case (rq.mode)
         MODE_INSERT: begin
            if (n_held < CAPACITY && locate_id(rq.entry_id) < 0) begin
               if (rq.entry_age >= age_threshold) begin
                  pos = n_pref;
                  for (int i = n_held; i > pos; i--) begin
                     q_ids[i]  = q_ids[i - 1];
                     q_ages[i] = q_ages[i - 1];
                  end
                  n_pref++;
               end else begin
                  pos = n_held;
               end
               q_ids[pos]  = rq.entry_id;
               q_ages[pos] = rq.entry_age;
               n_held++;
               r.ok = 1'b1;
            end
         end
         MODE_SERVE: begin
            if (n_held > 0) begin
               r.served_id = q_ids[0];
               drop_slot(0);
               r.ok = 1'b1;
            end
         end
         MODE_WITHDRAW: begin
            pos = locate_id(rq.entry_id);
            if (pos >= 0) begin
               drop_slot(pos);
               r.ok = 1'b1;
            end
         end
         default: begin
            pos = locate_id(rq.entry_id);
            if (pos >= 0) begin
               r.found_age = q_ages[pos];
               r.ok = 1'b1;
            end
         end
      endcase
      r.entry_count = 5'(n_held);
      return r;
   endfunction

   // one request transfer; prediction is made when it is accepted
   task automatic send_request(logic [1:0] mode, logic [15:0] id, logic [7:0] age);
      req_type rq;
      rq.mode = mode;
      rq.entry_id = id;
      rq.entry_age = age;
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(apply_request(rq));
      req_valid <= 1'b0;
      // the block is busy for at least this cycle after a transfer
      @(posedge clock);
   endtask

   // random id from a small pool so duplicates and hits are common
   function automatic logic [15:0] pick_id();
      logic [15:0] v;
      v = 16'($urandom_range(0, 23));
      if ($urandom_range(0, 9) == 0) v = 16'($urandom);
      return v;
   endfunction

   task automatic wait_idle();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      age_threshold = value;
   endtask

   // drain the queue by serving until empty
   task automatic flush_queue();
      while (n_held > 0) send_request(MODE_SERVE, '0, '0);
   endtask

   task automatic test_directed_edges();
      send_request(MODE_SERVE, 16'hFFFF, 8'hFF);            // serve when empty
      send_request(MODE_QUERY, 16'h0000, '0);               // query absent
      send_request(MODE_WITHDRAW, 16'hFFFF, '0);            // withdraw absent
      send_request(MODE_INSERT, 16'h0000, 8'h00);           // normal class
      send_request(MODE_INSERT, 16'hFFFF, 8'hFF);           // preferred class
      send_request(MODE_INSERT, 16'hFFFF, 8'h01);           // duplicate id
      send_request(MODE_INSERT, 16'h5A5A, 8'd60);           // exactly at threshold
      send_request(MODE_INSERT, 16'hA5A5, 8'd59);           // just below
      send_request(MODE_QUERY, 16'hFFFF, '0);
      send_request(MODE_QUERY, 16'hA5A5, '0);
      send_request(MODE_WITHDRAW, 16'hFFFF, '0);            // withdraw the head
      send_request(MODE_WITHDRAW, 16'hA5A5, '0);            // withdraw the tail
      for (int i = 0; i < 16; i++) send_request(MODE_INSERT, 16'(100 + i), 8'(i * 16));
      send_request(MODE_INSERT, 16'd999, 8'hFF);            // refused, queue full
      flush_queue();
   endtask

   task automatic test_random_ops(int n);
      int m;
      for (int k = 0; k < n; k++) begin
         m = $urandom_range(0, 9);
         if (m < 4)      send_request(MODE_INSERT, pick_id(), 8'($urandom));
         else if (m < 6) send_request(MODE_SERVE, 16'($urandom), 8'($urandom));
         else if (m < 8) send_request(MODE_WITHDRAW, pick_id(), 8'($urandom));
         else            send_request(MODE_QUERY, pick_id(), 8'($urandom));
      end
   endtask

   task automatic test_threshold_sweep();
      write_threshold(8'd0);          // every entry preferred
      test_random_ops(250);
      write_threshold(8'd255);
      test_random_ops(250);
      write_threshold(8'd128);
      test_random_ops(300);
      write_threshold(8'($urandom));
      test_random_ops(300);
   endtask

   task automatic test_no_gaps();
      send_gaps  = 1'b0;
      drain_gaps = 1'b0;
      write_threshold(THRESHOLD_RESET);
      test_random_ops(400);
   endtask

   // result side: random stall bursts and in-order comparison
   initial begin
      forever begin
         @(posedge clock);
         if (drain_gaps && !rsp_stall && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected transfer: expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            automatic rsp_type e = expected_rsps.pop_front();
            if (e.ok !== rsp_data.ok) begin
               $display("%0t ok: expected %h actual %h", $time, e.ok, rsp_data.ok);
               error_count++;
            end
            if (e.served_id !== rsp_data.served_id) begin
               $display("%0t served_id: expected %h actual %h", $time,
                        e.served_id, rsp_data.served_id);
               error_count++;
            end
            if (e.found_age !== rsp_data.found_age) begin
               $display("%0t found_age: expected %h actual %h", $time,
                        e.found_age, rsp_data.found_age);
               error_count++;
            end
            if (e.entry_count !== rsp_data.entry_count) begin
               $display("%0t entry_count: expected %h actual %h", $time,
                        e.entry_count, rsp_data.entry_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      n_pref = 0;
      n_held = 0;
      age_threshold = THRESHOLD_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_threshold_sweep();
      test_no_gaps();
      wait_idle();
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
